[design/rgb_to_ycbcr_420_quad_top_assert.svh]
// Assertion macros for the rgb_to_ycbcr_420_quad block.
`ifndef RGB_TO_YCBCR_420_QUAD_TOP_ASSERT_SVH
`define RGB_TO_YCBCR_420_QUAD_TOP_ASSERT_SVH

// Same-cycle check on clk_i, disabled in reset.
`define RYQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Next-cycle check on clk_i, disabled in reset.
`define RYQ_ASSERT_NXT(lbl, ante, cons, msg) \
  `RYQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[design/rgbq_pkg.sv]
// Types, coefficients and helpers for the RGB to YCbCr 4:2:0 quad converter.
package rgbq_pkg;

  typedef struct packed {
    logic [7:0] red_top_left;
    logic [7:0] green_top_left;
    logic [7:0] blue_top_left;
    logic [7:0] red_top_right;
    logic [7:0] green_top_right;
    logic [7:0] blue_top_right;
    logic [7:0] red_bottom_left;
    logic [7:0] green_bottom_left;
    logic [7:0] blue_bottom_left;
    logic [7:0] red_bottom_right;
    logic [7:0] green_bottom_right;
    logic [7:0] blue_bottom_right;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] luma_top_left;
    logic signed [7:0] luma_top_right;
    logic signed [7:0] luma_bottom_left;
    logic signed [7:0] luma_bottom_right;
    logic signed [7:0] blue_chroma;
    logic signed [7:0] red_chroma;
    logic        [7:0] luma_position;
    logic        [5:0] chroma_position;
    logic              last_of_block;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam int unsigned NumPix = 4;

  localparam logic [15:0] CoefYR  = 16'd19595;
  localparam logic [15:0] CoefYG  = 16'd38470;
  localparam logic [15:0] CoefYB  = 16'd7471;
  localparam logic [15:0] CoefCbR = 16'd11059;
  localparam logic [15:0] CoefCbG = 16'd21709;
  localparam logic [15:0] CoefCrG = 16'd27439;
  localparam logic [15:0] CoefCrB = 16'd5329;

  localparam logic [23:0] RoundBias = 24'd32767;
  localparam logic [5:0]  LastQuad  = 6'd63;

  // top-left luma index over four 8x8 luma blocks
  function automatic logic [7:0] luma_pos(input logic [5:0] cnt);
    luma_pos = {cnt[5], cnt[2], cnt[4], cnt[3], 1'b0, cnt[1], cnt[0], 1'b0};
  endfunction

endpackage

[design/rgbq_luma_lane.sv]
// One luma lane: registered products, then sum, rounding shift and level shift.
module rgbq_luma_lane (
  input  logic               clk_i,
  input  logic               load_i,
  input  rgbq_pkg::rgb_t     pix_i,
  output logic signed [7:0]  luma_o
);

  logic [23:0] prod_r_q, prod_g_q, prod_b_q;
  logic [23:0] sum;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_r_q <= {16'd0, pix_i.red}   * {8'd0, rgbq_pkg::CoefYR};
      prod_g_q <= {16'd0, pix_i.green} * {8'd0, rgbq_pkg::CoefYG};
      prod_b_q <= {16'd0, pix_i.blue}  * {8'd0, rgbq_pkg::CoefYB};
    end
  end

  // fits 24 bits for any 8-bit input
  assign sum    = prod_r_q + prod_g_q + prod_b_q + rgbq_pkg::RoundBias;
  assign luma_o = $signed({~sum[23], sum[22:16]});

endmodule

[design/rgbq_chroma.sv]
// Chroma core: quad average, registered products, then Cb and Cr sums.
module rgbq_chroma (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  rgbq_pkg::in_beat_t   beat_i,
  output logic signed [7:0]    cb_o,
  output logic signed [7:0]    cr_o
);

  logic [9:0]  sum_r, sum_g, sum_b;
  logic [7:0]  avg_r, avg_g, avg_b;
  logic [7:0]  avg_r_q, avg_b_q;
  logic [22:0] cb_r_q, cb_g_q, cr_g_q, cr_b_q;
  logic signed [24:0] cb_sum, cr_sum;

  assign sum_r = {2'd0, beat_i.red_top_left} + {2'd0, beat_i.red_top_right}
               + {2'd0, beat_i.red_bottom_left} + {2'd0, beat_i.red_bottom_right};
  assign sum_g = {2'd0, beat_i.green_top_left} + {2'd0, beat_i.green_top_right}
               + {2'd0, beat_i.green_bottom_left} + {2'd0, beat_i.green_bottom_right};
  assign sum_b = {2'd0, beat_i.blue_top_left} + {2'd0, beat_i.blue_top_right}
               + {2'd0, beat_i.blue_bottom_left} + {2'd0, beat_i.blue_bottom_right};

  assign avg_r = sum_r[9:2];
  assign avg_g = sum_g[9:2];
  assign avg_b = sum_b[9:2];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      avg_r_q <= avg_r;
      avg_b_q <= avg_b;
      cb_r_q  <= {15'd0, avg_r} * {7'd0, rgbq_pkg::CoefCbR};
      cb_g_q  <= {15'd0, avg_g} * {7'd0, rgbq_pkg::CoefCbG};
      cr_g_q  <= {15'd0, avg_g} * {7'd0, rgbq_pkg::CoefCrG};
      cr_b_q  <= {15'd0, avg_b} * {7'd0, rgbq_pkg::CoefCrB};
    end
  end

  // half coefficient is a shift by 15
  assign cb_sum = $signed({2'b00, avg_b_q, 15'd0}) + $signed({1'b0, rgbq_pkg::RoundBias})
                - $signed({2'b00, cb_r_q}) - $signed({2'b00, cb_g_q});
  assign cr_sum = $signed({2'b00, avg_r_q, 15'd0}) + $signed({1'b0, rgbq_pkg::RoundBias})
                - $signed({2'b00, cr_g_q}) - $signed({2'b00, cr_b_q});

  // both sums stay within 24-bit signed range
  assign cb_o = $signed(cb_sum[23:16]);
  assign cr_o = $signed(cr_sum[23:16]);

endmodule

[design/rgb_to_ycbcr_420_quad_top.sv]
// Top level of the RGB to YCbCr 4:2:0 quad converter with merge and output stage.
// Input accept to output valid passes the product register, then the output register.
// Throughput: one quad per cycle while the output is not stalled; four luma lanes and one chroma core run in parallel.
// Input ready drops only when both the product stage and the output register hold beats and out_ready_i is low.
// Reset: async active low, clears valid bits and the quad counter to zero.
`include "rgb_to_ycbcr_420_quad_top_assert.svh"

module rgb_to_ycbcr_420_quad_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rgbq_pkg::in_beat_t    in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rgbq_pkg::out_beat_t   out_beat_o
);

  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  logic [5:0]          cnt_q, cnt_d;
  logic [5:0]          s1_cnt_q;
  logic                adv_out, load_s1, load_out;
  rgbq_pkg::out_beat_t out_beat_q, out_beat_d;
  rgbq_pkg::rgb_t      lane_pix [rgbq_pkg::NumPix];
  logic signed [7:0]   lane_luma [rgbq_pkg::NumPix];
  logic signed [7:0]   cb, cr;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv_out;
  assign load_s1    = in_valid_i && in_ready_o;
  assign load_out   = adv_out && s1_valid_q;

  assign lane_pix[0] = {in_beat_i.red_top_left, in_beat_i.green_top_left,
                        in_beat_i.blue_top_left};
  assign lane_pix[1] = {in_beat_i.red_top_right, in_beat_i.green_top_right,
                        in_beat_i.blue_top_right};
  assign lane_pix[2] = {in_beat_i.red_bottom_left, in_beat_i.green_bottom_left,
                        in_beat_i.blue_bottom_left};
  assign lane_pix[3] = {in_beat_i.red_bottom_right, in_beat_i.green_bottom_right,
                        in_beat_i.blue_bottom_right};

  for (genvar k = 0; k < rgbq_pkg::NumPix; k++) begin : g_lane
    rgbq_luma_lane u_lane (
      .clk_i  (clk_i),
      .load_i (load_s1),
      .pix_i  (lane_pix[k]),
      .luma_o (lane_luma[k])
    );
  end

  rgbq_chroma u_chroma (
    .clk_i  (clk_i),
    .load_i (load_s1),
    .beat_i (in_beat_i),
    .cb_o   (cb),
    .cr_o   (cr)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    if (adv_out) begin
      out_valid_d = s1_valid_q;
    end
    if (load_s1) begin
      cnt_d = cnt_q + 6'd1;
    end
  end

  // merge lane results with block position
  always_comb begin
    out_beat_d.luma_top_left     = lane_luma[0];
    out_beat_d.luma_top_right    = lane_luma[1];
    out_beat_d.luma_bottom_left  = lane_luma[2];
    out_beat_d.luma_bottom_right = lane_luma[3];
    out_beat_d.blue_chroma       = cb;
    out_beat_d.red_chroma        = cr;
    out_beat_d.luma_position     = rgbq_pkg::luma_pos(s1_cnt_q);
    out_beat_d.chroma_position   = s1_cnt_q;
    out_beat_d.last_of_block     = (s1_cnt_q == rgbq_pkg::LastQuad);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= 6'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_s1) begin
      s1_cnt_q <= cnt_q;
    end
    if (load_out) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `RYQ_ASSERT_NXT(a_cnt_step, load_s1, cnt_q == $past(cnt_q) + 6'd1,
                  "quad counter did not step on accept")
  `RYQ_ASSERT(a_out_from_s1, $rose(out_valid_q) |-> $past(s1_valid_q),
              "output valid without a product-stage beat")
  `RYQ_ASSERT(a_full_on_stall, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i),
              "input stalled with room in the pipeline")
  `RYQ_ASSERT(a_last_pos,
              out_valid_q |-> (out_beat_q.last_of_block ==
                               (out_beat_q.chroma_position == rgbq_pkg::LastQuad)),
              "last flag disagrees with chroma position")
  `RYQ_ASSERT_NXT(a_s1_hold, s1_valid_q && !adv_out, s1_valid_q && $stable(s1_cnt_q),
                  "product stage lost its beat under stall")

endmodule
